/* rtl/lrc_pkg.sv */
`default_nettype none
package lrc_pkg;

	// request codes
	localparam logic [2:0] REQ_UP     = 3'd0;
	localparam logic [2:0] REQ_DOWN   = 3'd1;
	localparam logic [2:0] REQ_DELETE = 3'd2;
	localparam logic [2:0] REQ_UNDO   = 3'd3;
	localparam logic [2:0] REQ_QUERY  = 3'd4;

	// register indexes and reset values
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_START_ROW = 1'b1;
	localparam logic [10:0] ROW_COUNT_RST = 11'd8;
	localparam logic [9:0]  START_ROW_RST = 10'd0;

	typedef struct packed {
		logic [2:0] req_type;
		logic [9:0] step_count;
		logic [9:0] row_index;
	} lrc_in_t;

	typedef struct packed {
		logic [9:0] cursor_row;
		logic       row_present;
		logic       error_flag;
	} lrc_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DEL,
		ST_UNDO_RD,
		ST_UNDO_WR,
		ST_QUERY
	} lrc_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RESTART,
		OP_CLEAR,
		OP_ACCEPT,
		OP_WALK_STEP,
		OP_DELETE,
		OP_UNDO_POP,
		OP_UNDO_LINK
	} lrc_op_t;

	typedef struct packed {
		lrc_op_t op;
		logic    finish;
		logic    err;
		logic    query;
	} lrc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic steps_zero;
		logic steps_one;
		logic link_none;
		logic del_refused;
		logic stack_empty;
	} lrc_status_t;

endpackage
`default_nettype wire

/* rtl/lrc_ram.sv */
`default_nettype none
module lrc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/lrc_datapath.sv */
`default_nettype none
module lrc_datapath import lrc_pkg::*; #(
	parameter int unsigned MAX_ROWS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_sel,
	input  wire logic [31:0] cfg_wdata,
	input  wire lrc_in_t     item,
	input  wire lrc_cmd_t    cmd,
	output lrc_status_t      status,
	output logic [10:0]      row_count,
	output logic [9:0]       start_row,
	output logic             done,
	output lrc_out_t         result
);

	localparam int unsigned IW = $clog2(MAX_ROWS);
	localparam int unsigned LW = IW + 1;
	localparam int unsigned WW = (LW > 11) ? LW : 11;
	localparam logic [LW-1:0] NONE = LW'(MAX_ROWS);
	localparam logic [WW-1:0] MAXW = WW'(MAX_ROWS);
	localparam logic [IW-1:0] LAST = IW'(MAX_ROWS - 1);

	logic [10:0]   row_count_q;
	logic [9:0]    start_row_q;
	logic [IW-1:0] clr_q;
	logic [IW-1:0] cursor_q;
	logic [IW-1:0] cursor_d;
	logic [LW-1:0] level_q;
	logic [9:0]    steps_q;
	logic [2:0]    req_q;
	logic          row_ok_q;
	logic [IW-1:0] row_q;
	logic [IW-1:0] r_q;
	logic          done_q;
	lrc_out_t      result_q;

	logic [WW-1:0] rc_w;
	logic [WW-1:0] n_w;
	logic [WW-1:0] row_w;
	logic [LW-1:0] n;
	logic [IW-1:0] cursor_init;
	logic [LW-1:0] clr_l;
	logic [LW-1:0] clr_nx;
	logic [LW-1:0] clr_prev;
	logic [LW-1:0] clr_next;

	logic [LW-1:0] prev_rd;
	logic [LW-1:0] next_rd;
	logic          del_rd;
	logic [IW-1:0] stk_rd;
	logic [LW-1:0] link_sel;
	logic          p_ok;
	logic          q_ok;
	logic          stack_full;

	logic          prev_we;
	logic [IW-1:0] prev_wa;
	logic [LW-1:0] prev_wd;
	logic          next_we;
	logic [IW-1:0] next_wa;
	logic [LW-1:0] next_wd;
	logic          del_we;
	logic [IW-1:0] del_wa;
	logic          del_wd;
	logic          stk_we;
	logic [IW-1:0] stk_wa;
	logic [IW-1:0] link_ra;
	logic [IW-1:0] del_ra;
	logic [IW-1:0] stk_ra;

	// clamped row count and initial cursor
	always_comb begin
		rc_w  = WW'(row_count_q);
		row_w = WW'(item.row_index);
		if (rc_w == '0) begin
			n_w = WW'(1);
		end else if (rc_w > MAXW) begin
			n_w = MAXW;
		end else begin
			n_w = rc_w;
		end
		n = LW'(n_w);
		if (WW'(start_row_q) < n_w) begin
			cursor_init = IW'(start_row_q);
		end else begin
			cursor_init = IW'(n_w - WW'(1));
		end
	end

	// link values written by the rebuild sweep
	always_comb begin
		clr_l  = LW'(clr_q);
		clr_nx = clr_l + LW'(1);
		if (clr_q == '0 || clr_l >= n) begin
			clr_prev = NONE;
		end else begin
			clr_prev = clr_l - LW'(1);
		end
		clr_next = (clr_nx < n) ? clr_nx : NONE;
	end

	// neighbor decode
	assign link_sel   = (req_q == REQ_UP) ? prev_rd : next_rd;
	assign p_ok       = prev_rd < NONE;
	assign q_ok       = next_rd < NONE;
	assign stack_full = level_q >= NONE;

	// memory ports
	always_comb begin
		prev_we = 1'b0;
		prev_wa = cursor_q;
		prev_wd = '0;
		next_we = 1'b0;
		next_wa = cursor_q;
		next_wd = '0;
		del_we  = 1'b0;
		del_wa  = cursor_q;
		del_wd  = 1'b0;
		stk_we  = 1'b0;
		stk_wa  = IW'(level_q);
		link_ra = cursor_q;
		cursor_d = cursor_q;
		case (cmd.op)
			OP_CLEAR: begin
				prev_we  = 1'b1;
				prev_wa  = clr_q;
				prev_wd  = clr_prev;
				next_we  = 1'b1;
				next_wa  = clr_q;
				next_wd  = clr_next;
				del_we   = 1'b1;
				del_wa   = clr_q;
				cursor_d = cursor_init;
			end
			OP_WALK_STEP: begin
				link_ra  = IW'(link_sel);
				cursor_d = IW'(link_sel);
			end
			OP_DELETE: begin
				next_we  = p_ok;
				next_wa  = IW'(prev_rd);
				next_wd  = next_rd;
				prev_we  = q_ok;
				prev_wa  = IW'(next_rd);
				prev_wd  = prev_rd;
				del_we   = 1'b1;
				del_wd   = 1'b1;
				stk_we   = !stack_full;
				cursor_d = q_ok ? IW'(next_rd) : IW'(prev_rd);
			end
			OP_UNDO_POP: begin
				link_ra = stk_rd;
			end
			OP_UNDO_LINK: begin
				next_we = p_ok;
				next_wa = IW'(prev_rd);
				next_wd = LW'(r_q);
				prev_we = q_ok;
				prev_wa = IW'(next_rd);
				prev_wd = LW'(r_q);
				del_we  = 1'b1;
				del_wa  = r_q;
			end
			default: begin
			end
		endcase
	end

	assign del_ra = (cmd.op == OP_ACCEPT) ? IW'(item.row_index) : row_q;
	assign stk_ra = IW'(level_q - LW'(1));

	lrc_ram #(.WIDTH(LW), .DEPTH(MAX_ROWS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(link_ra), .rdata(prev_rd)
	);

	lrc_ram #(.WIDTH(LW), .DEPTH(MAX_ROWS)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(link_ra), .rdata(next_rd)
	);

	lrc_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_del (
		.clk(clk), .we(del_we), .waddr(del_wa), .wdata(del_wd),
		.raddr(del_ra), .rdata(del_rd)
	);

	lrc_ram #(.WIDTH(IW), .DEPTH(MAX_ROWS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(cursor_q),
		.raddr(stk_ra), .rdata(stk_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			start_row_q <= START_ROW_RST;
			clr_q       <= '0;
			cursor_q    <= '0;
			level_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == REG_ROW_COUNT) begin
					row_count_q <= cfg_wdata[10:0];
				end else begin
					start_row_q <= cfg_wdata[9:0];
				end
			end
			if (cmd.op == OP_RESTART) begin
				clr_q <= '0;
			end else if (cmd.op == OP_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			cursor_q <= cursor_d;
			case (cmd.op)
				OP_CLEAR:    level_q <= '0;
				OP_DELETE:   level_q <= stack_full ? level_q : level_q + LW'(1);
				OP_UNDO_POP: level_q <= level_q - LW'(1);
				default:     level_q <= level_q;
			endcase
			done_q <= cmd.finish;
		end
	end

	// request payload and result
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT) begin
			req_q    <= item.req_type;
			steps_q  <= item.step_count;
			row_q    <= IW'(item.row_index);
			row_ok_q <= (row_w < rc_w) && (row_w < MAXW);
		end else if (cmd.op == OP_WALK_STEP) begin
			steps_q <= steps_q - 10'd1;
		end
		if (cmd.op == OP_UNDO_POP) begin
			r_q <= stk_rd;
		end
		if (cmd.finish) begin
			result_q.cursor_row  <= 10'(cursor_d);
			result_q.row_present <= cmd.query & row_ok_q & ~del_rd;
			result_q.error_flag  <= cmd.err;
		end
	end

	assign status.clr_last    = clr_q == LAST;
	assign status.steps_zero  = steps_q == 10'd0;
	assign status.steps_one   = steps_q == 10'd1;
	assign status.link_none   = link_sel >= NONE;
	assign status.del_refused = !p_ok && !q_ok;
	assign status.stack_empty = level_q == '0;

	assign row_count = row_count_q;
	assign start_row = start_row_q;
	assign done      = done_q;
	assign result    = result_q;

endmodule
`default_nettype wire

/* rtl/lrc_ctrl.sv */
`default_nettype none
module lrc_ctrl import lrc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [2:0]  req_type,
	input  wire logic        cfg_we,
	input  wire lrc_status_t status,
	output lrc_cmd_t         cmd,
	output logic             busy
);

	lrc_state_t state_q;
	lrc_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.finish = 1'b0;
		cmd.err    = 1'b0;
		cmd.query  = 1'b0;
		busy       = state_q != ST_IDLE;
		if (cfg_we) begin
			cmd.op  = OP_RESTART;
			state_d = ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cmd.op = OP_CLEAR;
					if (status.clr_last) begin
						state_d = ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd.op = OP_ACCEPT;
						case (req_type)
							REQ_UP, REQ_DOWN: state_d = ST_WALK;
							REQ_DELETE:       state_d = ST_DEL;
							REQ_UNDO:         state_d = ST_UNDO_RD;
							REQ_QUERY:        state_d = ST_QUERY;
							default:          cmd.finish = 1'b1;
						endcase
					end
				end
				ST_WALK: begin
					if (status.steps_zero) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else if (status.link_none) begin
						cmd.finish = 1'b1;
						cmd.err    = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.op = OP_WALK_STEP;
						if (status.steps_one) begin
							cmd.finish = 1'b1;
							state_d    = ST_IDLE;
						end
					end
				end
				ST_DEL: begin
					cmd.finish = 1'b1;
					if (status.del_refused) begin
						cmd.err = 1'b1;
					end else begin
						cmd.op = OP_DELETE;
					end
					state_d = ST_IDLE;
				end
				ST_UNDO_RD: begin
					if (status.stack_empty) begin
						cmd.finish = 1'b1;
						cmd.err    = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.op  = OP_UNDO_POP;
						state_d = ST_UNDO_WR;
					end
				end
				ST_UNDO_WR: begin
					cmd.op     = OP_UNDO_LINK;
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
				ST_QUERY: begin
					cmd.finish = 1'b1;
					cmd.query  = 1'b1;
					state_d    = ST_IDLE;
				end
				default: begin
					state_d = ST_CLEAR;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/linked_row_cursor_with_undo_unit.sv */
`default_nettype none
// Row cursor over a doubly linked list of rows, with an undo stack of deletes.
// Command channel: a request transfer happens when start is high, busy is
// low and there is no configuration write; item carries req_type,
// step_count and row_index. Every request not cut short by a configuration
// write yields one result: done is high for exactly one cycle with result
// valid, and the receiver cannot stall it.
// An unknown request finishes as it is accepted; a query or a delete ends in
// its own state, an undo pops the stack, then relinks the row (error on an
// empty stack), and a walk takes one registered read of the link memories
// per step until the steps run out or it hits a list end (error).
// Configuration: APB-style, row_count at address 0, start_row at address 4,
// pready always high. A write rebuilds the list with a sweep over all MAX_ROWS
// entries of the link and flag memories, one entry per cycle; a further write
// restarts it, and busy stays high until it ends. Reset runs the same sweep
// with row_count 8 and start_row 0; the first request is taken once it ends.
module linked_row_cursor_with_undo_unit import lrc_pkg::*; #(
	parameter int unsigned MAX_ROWS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire lrc_in_t     item,
	output logic             done,
	output lrc_out_t         result
);

	logic        cfg_we;
	lrc_cmd_t    cmd;
	lrc_status_t status;
	logic [10:0] row_count;
	logic [9:0]  start_row;

	// register port decode
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_START_ROW) ? 32'(start_row) : 32'(row_count);

	lrc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(item.req_type),
		.cfg_we(cfg_we),
		.status(status),
		.cmd(cmd),
		.busy(busy)
	);

	lrc_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_sel(paddr[2]),
		.cfg_wdata(pwdata),
		.item(item),
		.cmd(cmd),
		.status(status),
		.row_count(row_count),
		.start_row(start_row),
		.done(done),
		.result(result)
	);

	// an accepted request is either still in work or reported next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cfg_we |=> busy || done)
		else $error("accepted request neither in work nor reported");

	// a result is only reported once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result reported while busy");

	// a query never flags an error, and only a query reports a present row
	a_present_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.row_present |-> !result.error_flag)
		else $error("present row reported with error");

endmodule
`default_nettype wire
